/* hdl/icmpc_pkg.sv */
// Shared types, constants and helper functions of the ICMP message checker.
`default_nettype none

package icmpc_pkg;

    // Fixed header length and minimum carried length of an error message.
    localparam logic [15:0] FIXED_HEADER      = 16'd8;
    localparam logic [15:0] MIN_CARRIED_BYTES = 16'd28;
    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

    // Message queue between front and back.
    localparam int          MQ_DEPTH = 4;
    localparam int          MQ_AW    = $clog2(MQ_DEPTH);
    localparam int          MQ_CW    = $clog2(MQ_DEPTH + 1);

    // Header octet positions.
    localparam logic [15:0] POS_TYPE   = 16'd0;
    localparam logic [15:0] POS_CODE   = 16'd1;
    localparam logic [15:0] POS_CSUM_H = 16'd2;
    localparam logic [15:0] POS_CSUM_L = 16'd3;
    localparam logic [15:0] POS_ID_H   = 16'd4;
    localparam logic [15:0] POS_ID_L   = 16'd5;
    localparam logic [15:0] POS_SEQ_H  = 16'd6;
    localparam logic [15:0] POS_SEQ_L  = 16'd7;

    // ICMP types.
    localparam logic [7:0]  TYPE_UNREACH  = 8'd3;
    localparam logic [7:0]  TYPE_QUENCH   = 8'd4;
    localparam logic [7:0]  TYPE_ECHO     = 8'd8;
    localparam logic [7:0]  TYPE_TIME_EXC = 8'd11;
    localparam logic [7:0]  TYPE_PARAM    = 8'd12;

    // Verdict codes.
    localparam logic [2:0]  V_ECHO_OK   = 3'd0;
    localparam logic [2:0]  V_ERROR_OK  = 3'd1;
    localparam logic [2:0]  V_MALFORMED = 3'd2;
    localparam logic [2:0]  V_BAD_CSUM  = 3'd3;
    localparam logic [2:0]  V_UNHANDLED = 3'd4;

    // Error classes.
    localparam logic [1:0]  EC_SOFT   = 2'd0;
    localparam logic [1:0]  EC_HARD   = 2'd1;
    localparam logic [1:0]  EC_QUENCH = 2'd2;
    localparam logic [1:0]  EC_NONE   = 2'd3;

    // One finished message as handed from front to back.
    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] sum;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] checksum;
        logic [15:0] identifier;
        logic [15:0] sequence_num;
    } icmpc_rec_t;

    // Ones-complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        begin
            s = {1'b0, a} + {1'b0, b};
            f = {1'b0, s[15:0]} + {16'd0, s[16]};
            return f[15:0];
        end
    endfunction

    function automatic logic [1:0] classify_error(input logic [7:0] t, input logic [7:0] c);
        logic [1:0] r;
        begin
            r = EC_NONE;
            if (t == TYPE_QUENCH) begin
                r = EC_QUENCH;
            end else if (t == TYPE_UNREACH) begin
                if (c == 8'd0 || c == 8'd1 || c == 8'd5) begin
                    r = EC_SOFT;
                end else if (c >= 8'd2 && c <= 8'd4) begin
                    r = EC_HARD;
                end
            end else if (t == TYPE_TIME_EXC) begin
                if (c == 8'd0 || c == 8'd1) begin
                    r = EC_SOFT;
                end
            end else if (t == TYPE_PARAM) begin
                r = EC_SOFT;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/icmpc_front.sv */
// Front part: byte capture, header field extraction and running checksum.
`default_nettype none

module icmpc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output icmpc_pkg::icmpc_rec_t  rec,
    output logic                   rec_push
);
    import icmpc_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  pending_reg, pending_next;
    logic        odd_reg, odd_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] csum_reg, csum_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] seq_reg, seq_next;

    logic [7:0]  summed;
    logic [15:0] word;
    logic [15:0] sum_added;
    logic [15:0] count_inc;

    always_comb
    begin
        type_next = type_reg;
        code_next = code_reg;
        csum_next = csum_reg;
        id_next   = id_reg;
        seq_next  = seq_reg;
        summed    = data_byte;
        case (byte_count_reg)
            POS_TYPE:   type_next = data_byte;
            POS_CODE:   code_next = data_byte;
            POS_CSUM_H:
            begin
                csum_next = {data_byte, csum_reg[7:0]};
                summed    = 8'd0;
            end
            POS_CSUM_L:
            begin
                csum_next = {csum_reg[15:8], data_byte};
                summed    = 8'd0;
            end
            POS_ID_H:   id_next  = {data_byte, id_reg[7:0]};
            POS_ID_L:   id_next  = {id_reg[15:8], data_byte};
            POS_SEQ_H:  seq_next = {data_byte, seq_reg[7:0]};
            POS_SEQ_L:  seq_next = {seq_reg[15:8], data_byte};
            default: ;
        endcase

        // Second octet of a word completes it; a lone final octet is zero-padded.
        word      = odd_reg ? {pending_reg, summed} : {summed, 8'd0};
        sum_added = oc_add(sum_reg, word);
        count_inc = (byte_count_reg == COUNT_MAX) ? byte_count_reg : byte_count_reg + 16'd1;

        sum_next     = (odd_reg || last_byte) ? sum_added : sum_reg;
        pending_next = odd_reg ? 8'd0 : summed;
        odd_next     = ~odd_reg;
        byte_count_next = count_inc;

        rec.byte_count   = count_inc;
        rec.sum          = sum_next;
        rec.msg_type     = type_next;
        rec.msg_code     = code_next;
        rec.checksum     = csum_next;
        rec.identifier   = id_next;
        rec.sequence_num = seq_next;
        rec_push         = accept && last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_count_reg <= '0;
            sum_reg        <= '0;
            pending_reg    <= '0;
            odd_reg        <= 1'b0;
            type_reg       <= '0;
            code_reg       <= '0;
            csum_reg       <= '0;
            id_reg         <= '0;
            seq_reg        <= '0;
        end else if (accept) begin
            if (last_byte) begin
                byte_count_reg <= '0;
                sum_reg        <= '0;
                pending_reg    <= '0;
                odd_reg        <= 1'b0;
                type_reg       <= '0;
                code_reg       <= '0;
                csum_reg       <= '0;
                id_reg         <= '0;
                seq_reg        <= '0;
            end else begin
                byte_count_reg <= byte_count_next;
                sum_reg        <= sum_next;
                pending_reg    <= pending_next;
                odd_reg        <= odd_next;
                type_reg       <= type_next;
                code_reg       <= code_next;
                csum_reg       <= csum_next;
                id_reg         <= id_next;
                seq_reg        <= seq_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/icmpc_queue.sv */
// Short message queue between front and back.
`default_nettype none

module icmpc_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire icmpc_pkg::icmpc_rec_t  wr_data,
    output logic                        full,
    input  wire logic                   rd_en,
    output icmpc_pkg::icmpc_rec_t       rd_data,
    output logic                        empty
);
    import icmpc_pkg::*;

    icmpc_rec_t         mem [MQ_DEPTH];
    logic [MQ_AW-1:0]   wr_ptr_reg;
    logic [MQ_AW-1:0]   rd_ptr_reg;
    logic [MQ_CW-1:0]   count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == MQ_CW'(MQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/icmpc_back.sv */
// Back part: verdict and error class, with the registered result stage.
`default_nettype none

module icmpc_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire icmpc_pkg::icmpc_rec_t  rec,
    input  wire logic                   rec_valid,
    output logic                        rec_take,
    input  wire logic                   pop,
    output logic                        empty,
    output logic [2:0]                  verdict,
    output logic [7:0]                  msg_type,
    output logic [7:0]                  msg_code,
    output logic [15:0]                 echo_identifier,
    output logic [15:0]                 echo_sequence,
    output logic [15:0]                 received_checksum,
    output logic [15:0]                 payload_bytes,
    output logic [1:0]                  error_class
);
    import icmpc_pkg::*;

    logic        valid_reg;
    logic [2:0]  verdict_reg, verdict_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] csum_reg, csum_next;
    logic [15:0] payload_reg, payload_next;
    logic [1:0]  class_reg, class_next;

    logic [15:0] computed;
    logic        is_error_type;

    assign rec_take = rec_valid && (!valid_reg || pop);

    always_comb
    begin
        computed      = ~rec.sum;
        is_error_type = (rec.msg_type == TYPE_UNREACH) || (rec.msg_type == TYPE_QUENCH) ||
                        (rec.msg_type == TYPE_TIME_EXC) || (rec.msg_type == TYPE_PARAM);
        payload_next  = rec.byte_count - FIXED_HEADER;
        type_next     = rec.msg_type;
        code_next     = rec.msg_code;
        id_next       = rec.identifier;
        seq_next      = rec.sequence_num;
        csum_next     = rec.checksum;
        class_next    = EC_NONE;

        if (rec.byte_count < FIXED_HEADER) begin
            // Runt message: everything but the verdict reads as zero.
            verdict_next = V_MALFORMED;
            payload_next = '0;
            type_next    = '0;
            code_next    = '0;
            id_next      = '0;
            seq_next     = '0;
            csum_next    = '0;
            class_next   = EC_SOFT;
        end else if (computed != rec.checksum) begin
            verdict_next = V_BAD_CSUM;
        end else if (rec.msg_type == TYPE_ECHO) begin
            verdict_next = (rec.msg_code == 8'd0) ? V_ECHO_OK : V_MALFORMED;
        end else if (is_error_type) begin
            if (payload_next < MIN_CARRIED_BYTES) begin
                verdict_next = V_MALFORMED;
            end else begin
                verdict_next = V_ERROR_OK;
                class_next   = classify_error(rec.msg_type, rec.msg_code);
            end
        end else begin
            verdict_next = V_UNHANDLED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (rec_take) begin
            valid_reg <= 1'b1;
        end else if (pop) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take) begin
            verdict_reg <= verdict_next;
            type_reg    <= type_next;
            code_reg    <= code_next;
            id_reg      <= id_next;
            seq_reg     <= seq_next;
            csum_reg    <= csum_next;
            payload_reg <= payload_next;
            class_reg   <= class_next;
        end
    end

    assign empty             = !valid_reg;
    assign verdict           = verdict_reg;
    assign msg_type          = type_reg;
    assign msg_code          = code_reg;
    assign echo_identifier   = id_reg;
    assign echo_sequence     = seq_reg;
    assign received_checksum = csum_reg;
    assign payload_bytes     = payload_reg;
    assign error_class       = class_reg;

endmodule

`default_nettype wire

/* hdl/icmp_message_checker_core.sv */
// Top level of the ICMP message checker: front, message queue and back.
`default_nettype none

// ICMP message checker. Octets of a message are pushed one per clock, while
// full is low, with last_byte marking the final octet; each message yields
// exactly one result item, popped from the result side. The input side
// accepts one octet every cycle while full is low: the running checksum is
// one 16-bit end-around-carry add per word, done in the front as the octet
// arrives. On the last octet the front hands the captured header, octet count
// and folded sum to a four-entry message queue; the back turns one queued
// message per cycle into a verdict while its result register is empty or
// being popped, and holds it there. When nothing is waiting, the verdict
// goes through the queue into the result register and ports. full rises only when
// four finished messages wait behind an unpopped result, so short messages
// against a stalled consumer are what throttles the input. Verdicts are
// checked in order: runt (under 8 octets, all fields zero), checksum mismatch,
// echo with nonzero code, error types 3/4/11/12 with under 28 carried octets,
// and other types not handled. error_class is meaningful only for error ok.
module icmp_message_checker_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       verdict,
    output logic [7:0]       msg_type,
    output logic [7:0]       msg_code,
    output logic [15:0]      echo_identifier,
    output logic [15:0]      echo_sequence,
    output logic [15:0]      received_checksum,
    output logic [15:0]      payload_bytes,
    output logic [1:0]       error_class
);
    import icmpc_pkg::*;

    logic        accept;
    icmpc_rec_t  front_rec;
    logic        front_push;
    icmpc_rec_t  queue_rec;
    logic        queue_empty;
    logic        back_take;

    // The input stalls only when the message queue is full.
    assign accept = push && !full;

    icmpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .rec       (front_rec),
        .rec_push  (front_push)
    );

    icmpc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_rec),
        .full    (full),
        .rd_en   (back_take),
        .rd_data (queue_rec),
        .empty   (queue_empty)
    );

    icmpc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .rec               (queue_rec),
        .rec_valid         (!queue_empty),
        .rec_take          (back_take),
        .pop               (pop),
        .empty             (empty),
        .verdict           (verdict),
        .msg_type          (msg_type),
        .msg_code          (msg_code),
        .echo_identifier   (echo_identifier),
        .echo_sequence     (echo_sequence),
        .received_checksum (received_checksum),
        .payload_bytes     (payload_bytes),
        .error_class       (error_class)
    );

    // An echo passes only with type 8 and code 0, and carries no error class.
    a_echo_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && verdict == V_ECHO_OK) |->
            (msg_type == TYPE_ECHO && msg_code == 8'd0 && error_class == EC_NONE))
        else $error("echo verdict with inconsistent fields");

    // An accepted error message always carries at least the minimum payload.
    a_error_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && verdict == V_ERROR_OK) |-> (payload_bytes >= MIN_CARRIED_BYTES))
        else $error("error verdict with short payload");

    // A last octet accepted into an empty pipeline shows up after passing the message queue and the result register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte && queue_empty && empty) |=> ##1 !empty)
        else $error("result missing after last octet");

    // The back never takes from an empty queue.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        back_take |-> !queue_empty)
        else $error("back took from empty queue");

endmodule

`default_nettype wire
